>>> sv/atis_pkg.sv
// shared types, constants and calibration tables of the accelerometer smoother
package atis_pkg;

  localparam int AVG_COUNT_DEF    = 16;
  localparam int TABLE_POINTS_DEF = 17;
  localparam int KEEP_RESET       = 154;
  localparam int NUM_AXES         = 3;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // finished group handed from the accumulator to the table unit
  typedef struct packed {
    logic [1:0] axis;
    logic [9:0] avg;
  } grp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MUL,
    ST_DIV,
    ST_MIX,
    ST_OUT
  } bk_state_t;

  function automatic logic signed [15:0] force_at(input logic [4:0] i);
    logic signed [15:0] r;
    case (i)
      5'd0:  r = -16'sd16384;
      5'd1:  r = -16'sd15137;
      5'd2:  r = -16'sd11585;
      5'd3:  r = -16'sd8192;
      5'd4:  r = -16'sd6270;
      5'd5:  r = -16'sd4240;
      5'd6:  r = -16'sd2845;
      5'd7:  r = -16'sd1428;
      5'd8:  r = 16'sd0;
      5'd9:  r = 16'sd1428;
      5'd10: r = 16'sd2845;
      5'd11: r = 16'sd4240;
      5'd12: r = 16'sd6270;
      5'd13: r = 16'sd8192;
      5'd14: r = 16'sd11585;
      5'd15: r = 16'sd15137;
      default: r = 16'sd16384;
    endcase
    return r;
  endfunction

  function automatic logic [9:0] cal_at(input logic [1:0] ax, input logic [4:0] i);
    logic [9:0] r;
    r = 10'd0;
    case (ax)
      AXIS_X: begin
        case (i)
          5'd0: r = 10'd365; 5'd1: r = 10'd381; 5'd2: r = 10'd434; 5'd3: r = 10'd486;
          5'd4: r = 10'd515; 5'd5: r = 10'd544; 5'd6: r = 10'd565; 5'd7: r = 10'd590;
          5'd8: r = 10'd610; 5'd9: r = 10'd633; 5'd10: r = 10'd657; 5'd11: r = 10'd679;
          5'd12: r = 10'd709; 5'd13: r = 10'd737; 5'd14: r = 10'd793; 5'd15: r = 10'd848;
          default: r = 10'd872;
        endcase
      end
      AXIS_Y: begin
        case (i)
          5'd0: r = 10'd362; 5'd1: r = 10'd382; 5'd2: r = 10'd436; 5'd3: r = 10'd489;
          5'd4: r = 10'd518; 5'd5: r = 10'd549; 5'd6: r = 10'd569; 5'd7: r = 10'd593;
          5'd8: r = 10'd610; 5'd9: r = 10'd634; 5'd10: r = 10'd659; 5'd11: r = 10'd680;
          5'd12: r = 10'd709; 5'd13: r = 10'd737; 5'd14: r = 10'd790; 5'd15: r = 10'd843;
          default: r = 10'd863;
        endcase
      end
      default: begin
        case (i)
          5'd0: r = 10'd340; 5'd1: r = 10'd330; 5'd2: r = 10'd384; 5'd3: r = 10'd437;
          5'd4: r = 10'd465; 5'd5: r = 10'd489; 5'd6: r = 10'd510; 5'd7: r = 10'd534;
          5'd8: r = 10'd556; 5'd9: r = 10'd576; 5'd10: r = 10'd603; 5'd11: r = 10'd621;
          5'd12: r = 10'd650; 5'd13: r = 10'd678; 5'd14: r = 10'd731; 5'd15: r = 10'd787;
          default: r = 10'd807;
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

>>> sv/atis_front.sv
// front end: per-axis sample accumulation and group averaging
module atis_front #(
  parameter int AVG_COUNT = atis_pkg::AVG_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_axis,
  input  logic [9:0]    in_sample,
  output logic          grp_valid,
  input  logic          grp_ready,
  output atis_pkg::grp_t grp
);
  import atis_pkg::*;

  localparam logic [5:0] TALLY_END = 6'(AVG_COUNT);

  logic [15:0] sample_sum   [NUM_AXES];
  logic [5:0]  sample_tally [NUM_AXES];
  logic        hold_valid;
  grp_t        hold;
  logic        take;
  logic [15:0] sum_next;
  logic [5:0]  tally_next;
  logic [1:0]  ax;

  assign ax         = (in_axis == 2'd3) ? AXIS_X : in_axis;
  assign in_ready   = !hold_valid;
  assign take       = in_valid && in_ready && (in_axis != 2'd3);
  assign sum_next   = sample_sum[ax] + {6'd0, in_sample};
  assign tally_next = sample_tally[ax] + 6'd1;
  assign grp_valid  = hold_valid;
  assign grp        = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      for (int k = 0; k < NUM_AXES; k++) begin
        sample_sum[k]   <= '0;
        sample_tally[k] <= '0;
      end
    end else begin
      if (grp_valid && grp_ready) hold_valid <= 1'b0;
      if (take) begin
        if (tally_next == TALLY_END) begin
          sample_sum[ax]   <= '0;
          sample_tally[ax] <= '0;
          hold_valid       <= 1'b1;
          hold.axis        <= ax;
          hold.avg         <= 10'(sum_next / AVG_COUNT);
        end else begin
          sample_sum[ax]   <= sum_next;
          sample_tally[ax] <= tally_next;
        end
      end
    end
  end
endmodule

>>> sv/atis_queue.sv
// short fifo between front and back end
module atis_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  atis_pkg::grp_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output atis_pkg::grp_t rd_data
);
  import atis_pkg::*;

  grp_t       mem [QUEUE_DEPTH];
  logic       wp, rp;
  logic [1:0] fill;
  logic       wr, rd;

  assign wr_ready = (fill != 2'(QUEUE_DEPTH));
  assign rd_valid = (fill != 2'd0);
  assign rd_data  = mem[rp];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_data;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; fill <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      fill <= fill + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

>>> sv/atis_back.sv
// back end: table search, serial interpolation divide and smoothing
module atis_back #(
  parameter int TABLE_POINTS = atis_pkg::TABLE_POINTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [8:0]        keep_weight,
  input  logic              grp_valid,
  output logic              grp_ready,
  input  atis_pkg::grp_t    grp,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_axis,
  output logic [9:0]        average_count,
  output logic signed [15:0] force_res,
  output logic signed [15:0] smoothed_force
);
  import atis_pkg::*;

  localparam logic [4:0] LAST = 5'(TABLE_POINTS - 1);

  bk_state_t state, state_next;
  logic [1:0]  ax;
  logic [9:0]  avg;
  logic [4:0]  idx;
  logic signed [15:0] f_lo, frc;
  logic [9:0]  dy;
  logic [25:0] rem_num;   // |dx*dc|, dividend shifts out as quotient
  logic [10:0] rem;
  logic        neg;
  logic [4:0]  bitc;
  logic signed [15:0] smv [NUM_AXES];
  logic signed [15:0] smo;
  logic        ovalid;
  logic [9:0]  c_i, c_p;
  logic signed [16:0] dx;
  logic [9:0]  dc;
  logic signed [27:0] prod;
  logic [10:0] rtry;
  logic        qbit;
  logic [14:0] quo;       // quotient including the bit settled this step
  logic [8:0]  keep;
  logic signed [26:0] mix;

  assign c_i  = cal_at(ax, idx);
  assign c_p  = cal_at(ax, idx - 5'd1);
  assign keep = keep_weight[8] ? 9'd256 : keep_weight;
  assign rtry = {rem[9:0], rem_num[25]};
  assign qbit = (rtry >= {1'b0, dy});
  assign quo  = {rem_num[13:0], qbit};
  assign dx   = 17'(force_at(idx)) - 17'(force_at(idx - 5'd1));
  assign dc   = avg - c_p;
  assign prod = 28'(dx) * $signed({18'd0, dc});
  assign mix  = 27'($signed({1'b0, keep}) * smv[ax])
              + 27'($signed(10'd256 - {1'b0, keep}) * frc);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (grp_valid) state_next = ST_SEARCH;
      ST_SEARCH: if (idx == 5'd0 && c_i > avg) state_next = ST_MIX;
                 else if (idx != 5'd0 && c_i > avg) state_next = ST_MUL;
                 else if (idx == LAST) state_next = ST_MIX;
      ST_MUL:    state_next = ST_DIV;
      ST_DIV:    if (bitc == 5'd25) state_next = ST_MIX;
      ST_MIX:    state_next = ST_OUT;
      ST_OUT:    if (!ovalid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    grp_ready = (state == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      ovalid <= 1'b0;
      for (int k = 0; k < NUM_AXES; k++) smv[k] <= '0;
    end else begin
      state <= state_next;
      if (ovalid && out_ready) ovalid <= 1'b0;
      case (state)
        ST_IDLE: if (grp_valid) begin
          ax <= grp.axis; avg <= grp.avg; idx <= 5'd0;
        end
        ST_SEARCH: begin
          if (c_i > avg) frc <= force_at(idx);
          else if (idx == LAST) frc <= force_at(LAST);
          else idx <= idx + 5'd1;
          f_lo <= force_at(idx - 5'd1);
          dy   <= c_i - c_p;
        end
        ST_MUL: begin
          neg     <= prod[27];
          rem_num <= prod[27] ? 26'(-prod) : 26'(prod);
          rem     <= '0;
          bitc    <= 5'd0;
        end
        ST_DIV: begin
          bitc <= bitc + 5'd1;
          if (qbit) begin
            rem     <= rtry - {1'b0, dy};
            rem_num <= {rem_num[24:0], 1'b1};
          end else begin
            rem     <= rtry;
            rem_num <= {rem_num[24:0], 1'b0};
          end
          if (bitc == 5'd25)
            frc <= f_lo + (neg ? -16'(quo) : 16'(quo));
        end
        ST_MIX: begin
          smo     <= 16'(mix >>> 8);
          smv[ax] <= 16'(mix >>> 8);
        end
        ST_OUT: if (!ovalid || out_ready) begin
          ovalid         <= 1'b1;
          out_axis       <= ax;
          average_count  <= avg;
          force_res      <= frc;
          smoothed_force <= smo;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = ovalid;
endmodule

>>> sv/accel_table_interp_smoother.sv
// top level of the accelerometer table interpolation smoother
// processing: a group-closing item goes through the table search (one entry a cycle)
//   and, for a point inside the table, a 26-step restoring divider for the interpolation
// throughput: one sample a cycle in the front while no finished group waits for the queue;
//   the back takes a new group only after the last result is registered, decoupled by a two-entry queue
// reset: synchronous rst clears sums, tallies, smoothed values, keep_weight to 154
module accel_table_interp_smoother #(
  parameter int AVG_COUNT    = atis_pkg::AVG_COUNT_DEF,
  parameter int TABLE_POINTS = atis_pkg::TABLE_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // sample, zero fill
  input  logic [1:0]  s_axis_tuser,   // axis
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // average_count, force_res, smoothed_force, zero fill
  output logic [1:0]  m_axis_tuser,   // out_axis
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata       // keep_weight
);
  import atis_pkg::*;

  logic [8:0] keep_weight;
  logic fv, fr, qv, qr;
  grp_t fg, qg;
  logic [9:0] avg;
  logic signed [15:0] frc, smo;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) keep_weight <= 9'(KEEP_RESET);
    else if (cfg_we) keep_weight <= cfg_wdata;
  end

  // front: accumulate and average
  atis_front #(.AVG_COUNT(AVG_COUNT)) u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_axis(s_axis_tuser), .in_sample(s_axis_tdata[9:0]),
    .grp_valid(fv), .grp_ready(fr), .grp(fg)
  );

  // decoupling queue
  atis_queue u_queue (
    .clk, .rst, .wr_valid(fv), .wr_ready(fr), .wr_data(fg),
    .rd_valid(qv), .rd_ready(qr), .rd_data(qg)
  );

  // back: interpolate and smooth
  atis_back #(.TABLE_POINTS(TABLE_POINTS)) u_back (
    .clk, .rst, .keep_weight, .grp_valid(qv), .grp_ready(qr), .grp(qg),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_axis(m_axis_tuser),
    .average_count(avg), .force_res(frc), .smoothed_force(smo)
  );

  assign m_axis_tdata = {6'd0, smo, frc, avg};
endmodule

>>> sim/testbench.sv
// self-checking testbench for the accelerometer table interpolation smoother
`timescale 1ns / 100ps

module testbench;
  import atis_pkg::*;

  typedef struct {
    logic [1:0] axis;
    logic [9:0] sample;
  } smp_item_t;

  typedef struct {
    logic [1:0]         axis;
    logic [9:0]         avg;
    logic signed [15:0] force_q;
    logic signed [15:0] smooth_q;
  } group_res_t;

  localparam int AXIS_NONE  = 3;
  localparam int CYCLE_CAP  = 1000000;
  localparam int DRAIN_WAIT = 80;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // sample, zero fill
  logic [1:0]  s_axis_tuser;   // axis
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // average_count, force_res, smoothed_force, zero fill
  logic [1:0]  m_axis_tuser;   // out_axis
  logic        cfg_we;
  logic [8:0]  cfg_wdata;

  accel_table_interp_smoother dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // predictor state, mirrors the block's registers
  logic [15:0]        acc_sum   [3];
  logic [5:0]         acc_tally [3];
  logic signed [15:0] smooth_st [3];
  logic [8:0]         keep_w;

  smp_item_t  pending_smp[$];
  group_res_t expected_groups[$];
  int  fail_count;
  longint cycle_no;
  bit  recv_hold;      // long receiver hold-off request
  int  hold_cycles;

  // own copy of the calibration tables
  int cal_tab [3][17] = '{
    '{365,381,434,486,515,544,565,590,610,633,657,679,709,737,793,848,872},
    '{362,382,436,489,518,549,569,593,610,634,659,680,709,737,790,843,863},
    '{340,330,384,437,465,489,510,534,556,576,603,621,650,678,731,787,807}};
  int force_tab [17] = '{-16384,-15137,-11585,-8192,-6270,-4240,-2845,-1428,
    0,1428,2845,4240,6270,8192,11585,15137,16384};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // piecewise-linear lookup, division truncates toward zero as in sv
  function automatic int interp_force(input int ax, input int cnt);
    int i;
    int dy;
    if (cal_tab[ax][0] > cnt) return force_tab[0];
    for (i = 1; i < 17; i++)
      if (cal_tab[ax][i] > cnt) begin
        dy = cal_tab[ax][i] - cal_tab[ax][i-1];
        if (dy <= 0) return force_tab[i-1];
        return force_tab[i-1] +
          ((force_tab[i] - force_tab[i-1]) * (cnt - cal_tab[ax][i-1])) / dy;
      end
    return force_tab[16];
  endfunction

  // advance the predictor by one accepted sample
  task automatic predict_sample(input smp_item_t it);
    int ax, avg, frc, kw, mix;
    group_res_t r;
    ax = it.axis;
    if (ax == AXIS_NONE) return;   // axis three is ignored entirely
    acc_sum[ax]   = acc_sum[ax] + it.sample;
    acc_tally[ax] = acc_tally[ax] + 1;
    if (acc_tally[ax] != 6'(AVG_COUNT_DEF)) return;
    avg = acc_sum[ax] / AVG_COUNT_DEF;
    acc_sum[ax] = '0;
    acc_tally[ax] = '0;
    frc = interp_force(ax, avg);
    kw  = (keep_w > 256) ? 256 : keep_w;   // weight saturates at one
    mix = kw * int'(smooth_st[ax]) + (256 - kw) * frc;
    smooth_st[ax] = 16'(mix >>> 8);        // floor division by 256
    r.axis = it.axis; r.avg = avg[9:0];
    r.force_q = 16'(frc); r.smooth_q = smooth_st[ax];
    expected_groups.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_no);
    fail_count++;
  endtask

  // sender: bursts of random length with random gaps
  int burst_left, gap_left;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      burst_left <= 0; gap_left <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_sample(pending_smp.pop_front());
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_smp.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          // next item: head, or the one after it if the head just went
          smp_item_t nx;
          nx = pending_smp[0];
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {6'd0, nx.sample};
          s_axis_tuser <= nx.axis;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end else burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver: own stall pattern, plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= 0;
    end else begin
      if (recv_hold && hold_cycles == 0) hold_cycles <= 600;
      else if (hold_cycles > 1) hold_cycles <= hold_cycles - 1;
      if (hold_cycles > 1 || (recv_hold && hold_cycles == 0))
        m_axis_tready <= 1'b0;
      else if (cycle_no[9:8] == 2'b00)
        m_axis_tready <= 1'b1;   // stretch with no stalls
      else
        m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_groups.size() == 0) begin
        $display("unexpected result at cycle %0d", cycle_no);
        fail_count++;
      end else begin
        group_res_t e;
        e = expected_groups.pop_front();
        if (m_axis_tuser !== e.axis)
          report_mismatch("out_axis", m_axis_tuser, e.axis);
        if (m_axis_tdata[9:0] !== e.avg)
          report_mismatch("average_count", m_axis_tdata[9:0], e.avg);
        if ($signed(m_axis_tdata[25:10]) !== e.force_q)
          report_mismatch("force_res", $signed(m_axis_tdata[25:10]), e.force_q);
        if ($signed(m_axis_tdata[41:26]) !== e.smooth_q)
          report_mismatch("smoothed_force", $signed(m_axis_tdata[41:26]), e.smooth_q);
        if (m_axis_tdata[47:42] !== 6'd0)
          report_mismatch("zero fill", m_axis_tdata[47:42], 0);
      end
    end
  end

  // cycle counter with timeout
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no > CYCLE_CAP) begin
      $display("timeout");
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic add_smp(input int ax, input int smp);
    smp_item_t it;
    it.axis = ax[1:0]; it.sample = smp[9:0];
    pending_smp.push_back(it);
  endtask

  // full group of one axis around a centre value
  task automatic add_group(input int ax, input int centre, input int spread);
    int k, v;
    for (k = 0; k < AVG_COUNT_DEF; k++) begin
      v = centre + $urandom_range(0, 2 * spread) - spread;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      add_smp(ax, v);
    end
  endtask

  task automatic settle();
    while (pending_smp.size() != 0 || s_axis_tvalid || expected_groups.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // write keep_weight while the block is idle
  task automatic write_keep(input int w);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_wdata <= w[8:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    keep_w = w[8:0];
  endtask

  int n, ax, phase;
  int weights[6] = '{0, 256, 511, 1, 257, 200};
  initial begin
    rst = 1'b1; cycle_no = 0; fail_count = 0; recv_hold = 0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
    m_axis_tready = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
    keep_w = 9'(KEEP_RESET);
    for (int i = 0; i < 3; i++) begin
      acc_sum[i] = '0; acc_tally[i] = '0; smooth_st[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, ignored axis, table ends, exact entries
    add_group(AXIS_X, 0, 0);           // below first entry
    add_group(AXIS_Y, 1023, 0);        // above last entry
    add_smp(AXIS_NONE, 1023);          // ignored axis
    add_smp(AXIS_NONE, 0);
    add_group(AXIS_Z, 335, 0);         // non-monotonic start of the z table
    settle();
    add_group(AXIS_X, 872, 0);         // exactly last entry
    add_group(AXIS_Z, 340, 0);
    add_group(AXIS_Y, 610, 0);         // exactly an inner entry
    add_group(AXIS_X, 682, 1);
    settle();

    // random phases, one weight setting each; sender pauses at each end
    for (phase = 0; phase < 6; phase++) begin
      write_keep(weights[phase]);
      for (n = 0; n < 15; n++) begin
        ax = $urandom_range(0, 2);
        case ($urandom_range(0, 5))
          0: add_group(ax, $urandom_range(0, 1023), 511);
          1: add_group(ax, $urandom_range(0, 1) ? 0 : 1023, 3);
          default: add_group(ax, $urandom_range(320, 880), $urandom_range(0, 20));
        endcase
        if ($urandom_range(0, 3) == 0) add_smp(AXIS_NONE, $urandom_range(0, 1023));
        // interleaved partial noise from a random axis
        if ($urandom_range(0, 2) == 0) add_smp($urandom_range(0, 2), $urandom_range(0, 1023));
      end
      if (phase == 2) begin
        // long hold-off while samples keep coming
        recv_hold <= 1;
        @(posedge clk);
        recv_hold <= 0;
      end
      settle();
    end
    write_keep(KEEP_RESET);
    add_group(AXIS_X, 700, 5);
    add_group(AXIS_Y, 700, 5);
    add_group(AXIS_Z, 700, 5);
    settle();

    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
